// ===== hw/rtl/dalq_pkg.sv =====
// Shared types and constants of the deadline alarm queue.
package dalq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int TIME_W      = 32;
  localparam int FIELD_W     = 16;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic               is_tick;
    logic [FIELD_W-1:0] delay;
    logic [FIELD_W-1:0] tag;
  } cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0]  deadline;
    logic [FIELD_W-1:0] tag;
    logic [FIELD_W-1:0] delay;
  } entry_t;

  typedef struct packed {
    logic [FIELD_W-1:0] tag;
    logic [FIELD_W-1:0] delay;
    logic               rejected;
    logic               last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADD  = 3'b010,
    ST_TICK = 3'b100
  } state_t;

endpackage

// ===== hw/rtl/dalq_front.sv =====
// Input side: accepts and classifies items into a short command queue.
module dalq_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [31:0]          in_tdata,   // delay_seconds[15:0], alarm_id[31:16]
  input  logic                 in_tuser,   // mode
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output dalq_pkg::cmd_t       cmd
);

  dalq_pkg::cmd_t                 fifo_r [dalq_pkg::FIFO_DEPTH];
  logic [dalq_pkg::FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [dalq_pkg::FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [dalq_pkg::FIFO_AW:0]     cnt_r, cnt_nxt;
  dalq_pkg::cmd_t                 in_cmd;
  logic                           push, pop;

  always_comb begin
    in_cmd.is_tick = (in_tuser == dalq_pkg::MODE_TICK);
    in_cmd.delay   = in_tdata[15:0];
    in_cmd.tag     = in_tdata[31:16];
  end

  assign in_tready = (cnt_r != (dalq_pkg::FIFO_AW + 1)'(dalq_pkg::FIFO_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = fifo_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + dalq_pkg::FIFO_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + dalq_pkg::FIFO_AW'(1) : rd_ptr_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + (dalq_pkg::FIFO_AW + 1)'(1);
      2'b01:   cnt_nxt = cnt_r - (dalq_pkg::FIFO_AW + 1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

// ===== hw/rtl/dalq_back.sv =====
// Execution side: time count, sorted alarm table and result register.
module dalq_back #(
  parameter int QUEUE_DEPTH = dalq_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  dalq_pkg::cmd_t      cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output dalq_pkg::result_t   res
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [dalq_pkg::TIME_W-1:0] TIME_MAX = '1;

  dalq_pkg::state_t               state_r, state_nxt;
  dalq_pkg::entry_t               ent_r   [QUEUE_DEPTH];
  dalq_pkg::entry_t               ent_nxt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]         ge;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [dalq_pkg::TIME_W-1:0]    now_r, now_nxt;
  logic [dalq_pkg::TIME_W-1:0]    deadline_r, deadline_nxt;
  logic [dalq_pkg::TIME_W:0]      sum;
  logic [dalq_pkg::FIELD_W-1:0]   tag_r, tag_nxt, dly_r, dly_nxt;
  logic                           expire_r, expire_nxt;
  logic [dalq_pkg::EMIT_W-1:0]    emit_r, emit_nxt;
  logic                           out_valid_r;
  dalq_pkg::result_t              out_res_r, load_res;
  logic                           out_free, load, do_insert, do_pop, full, due;
  dalq_pkg::entry_t               new_ent;

  assign out_free  = !out_valid_r || res_ready;
  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign cmd_ready = (state_r == dalq_pkg::ST_IDLE);
  assign res_valid = out_valid_r;
  assign res       = out_res_r;
  assign sum       = {1'b0, now_r} + {{(dalq_pkg::TIME_W - dalq_pkg::FIELD_W + 1){1'b0}},
                                      cmd.delay};
  assign due       = (count_r != '0) && (ent_r[0].deadline <= now_r)
                     && (emit_r != dalq_pkg::EMIT_W'(dalq_pkg::MAX_RESULTS));

  always_comb begin
    new_ent.deadline = deadline_r;
    new_ent.tag      = tag_r;
    new_ent.delay    = dly_r;
  end

  // Each cell decides locally from its own compare and its neighbor's.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    dalq_pkg::entry_t ins_v, pop_v;
    assign ge[g] = (CW'(g) >= count_r) || (ent_r[g].deadline >= deadline_r);
    if (g == 0) begin : g_head
      assign ins_v = new_ent;
    end else begin : g_body
      assign ins_v = ge[g-1] ? ent_r[g-1] : new_ent;
    end
    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign pop_v = ent_r[g];
    end else begin : g_mid
      assign pop_v = ent_r[g+1];
    end
    assign ent_nxt[g] = (do_insert && ge[g]) ? ins_v : (do_pop ? pop_v : ent_r[g]);
  end

  always_comb begin
    state_nxt    = state_r;
    now_nxt      = now_r;
    deadline_nxt = deadline_r;
    tag_nxt      = tag_r;
    dly_nxt      = dly_r;
    expire_nxt   = expire_r;
    emit_nxt     = emit_r;
    count_nxt    = count_r;
    load         = 1'b0;
    do_insert    = 1'b0;
    do_pop       = 1'b0;
    load_res     = out_res_r;
    unique case (state_r)
      dalq_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_tick) begin
            if (now_r != TIME_MAX) begin
              now_nxt = now_r + dalq_pkg::TIME_W'(1);
            end
            emit_nxt  = '0;
            state_nxt = dalq_pkg::ST_TICK;
          end else begin
            deadline_nxt = sum[dalq_pkg::TIME_W] ? TIME_MAX : sum[dalq_pkg::TIME_W-1:0];
            expire_nxt   = (cmd.delay == '0) || (now_r == TIME_MAX);
            tag_nxt      = cmd.tag;
            dly_nxt      = cmd.delay;
            state_nxt    = dalq_pkg::ST_ADD;
          end
        end
      end
      dalq_pkg::ST_ADD: begin
        if (expire_r || full) begin
          if (out_free) begin
            load              = 1'b1;
            load_res.tag      = tag_r;
            load_res.delay    = dly_r;
            load_res.rejected = !expire_r;
            load_res.last     = 1'b1;
            state_nxt         = dalq_pkg::ST_IDLE;
          end
        end else begin
          do_insert = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = dalq_pkg::ST_IDLE;
        end
      end
      dalq_pkg::ST_TICK: begin
        if (!due) begin
          state_nxt = dalq_pkg::ST_IDLE;
        end else if (out_free) begin
          load              = 1'b1;
          do_pop            = 1'b1;
          load_res.tag      = ent_r[0].tag;
          load_res.delay    = ent_r[0].delay;
          load_res.rejected = 1'b0;
          load_res.last     = (emit_r == dalq_pkg::EMIT_W'(dalq_pkg::MAX_RESULTS - 1))
                              || (count_r == CW'(1)) || (ent_r[1].deadline > now_r);
          count_nxt         = count_r - CW'(1);
          emit_nxt          = emit_r + dalq_pkg::EMIT_W'(1);
        end
      end
      default: state_nxt = dalq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dalq_pkg::ST_IDLE;
      now_r       <= '0;
      count_r     <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      count_r     <= count_nxt;
      emit_r      <= emit_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    deadline_r <= deadline_nxt;
    tag_r      <= tag_nxt;
    dly_r      <= dly_nxt;
    expire_r   <= expire_nxt;
    if (load) begin
      out_res_r <= load_res;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("Alarm count exceeds table depth.");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (load && load_res.rejected) |-> full)
    else $error("Add rejected while the table had room.");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (count_r == $past(count_r) - CW'(1)))
    else $error("Expiry did not remove exactly one entry.");

  a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_r == dalq_pkg::EMIT_W'(dalq_pkg::MAX_RESULTS)) |-> !do_pop)
    else $error("Tick emitted more alarms than allowed.");

endmodule

// ===== hw/rtl/deadline_alarm_queue.sv =====
// Top level of the deadline alarm queue: a sorted timer queue with a streaming interface.
//
// Items enter a two-entry command queue, one per cycle while it has room, and the
// execution side works on one command at a time. An add is dequeued with its deadline
// computed, then inserted into the table or loaded as a result once the result register
// is free; a tick advances the time count on dequeue, then removes expired alarms from
// the head one at a time, at most MAX_RESULTS of them, with the single result register
// and the downstream tready setting the pace of the expiry sequence. The alarm table is
// a row of QUEUE_DEPTH cells kept sorted by deadline, so an insert or a removal from the
// head is done by all cells in parallel. No clearing pass follows reset.
module deadline_alarm_queue #(
  parameter int QUEUE_DEPTH = dalq_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // delay_seconds[15:0], alarm_id[31:16]
  input  logic        in_tuser,    // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // alarm_id_res[15:0], delay_seconds_res[31:16]
  output logic        out_tuser,   // rejected
  output logic        out_tlast
);

  logic              cmd_valid, cmd_ready;
  dalq_pkg::cmd_t    cmd;
  dalq_pkg::result_t res;

  dalq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dalq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.delay, res.tag};
  assign out_tuser = res.rejected;
  assign out_tlast = res.last;

endmodule

// ===== sim/deadline_alarm_queue_tb.sv =====
// Self-checking testbench of the deadline alarm queue with a built-in timer table predictor.
module deadline_alarm_queue_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct {
    logic        mode;
    logic [15:0] delay;
    logic [15:0] tag;
    logic        drain;
  } alarm_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  alarm_cmd_t          alarm_cmd_q[$];
  dalq_pkg::result_t   due_results_q[$];
  dalq_pkg::entry_t    pending_alarms[$];
  logic [31:0]         now_ticks = '0;

  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int          settle_cnt = SETTLE_CYCLES;
  int          send_gap = 0;
  int          ready_stall = 0;
  int          cycle_cnt = 0;
  logic        calm;
  logic        drain_next = 1'b0;

  int          err_cnt = 0;
  int          adds_seen = 0;
  int          ticks_seen = 0;
  int          rejects_cnt = 0;
  int          immediate_cnt = 0;
  int          expired_cnt = 0;
  int          biggest_burst = 0;
  int          drain_pauses = 0;

  assign calm = (cycle_cnt % 3000) < 500;

  deadline_alarm_queue i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void queue_result(input logic [15:0] id, input logic [15:0] dly,
                                       input logic rej, input logic fin);
    dalq_pkg::result_t res;
    res.tag      = id;
    res.delay    = dly;
    res.rejected = rej;
    res.last     = fin;
    due_results_q.push_back(res);
  endfunction

  function automatic void predict_alarm(input logic mode, input logic [15:0] dly,
                                        input logic [15:0] id);
    logic [32:0]      sum;
    logic [31:0]      dl;
    dalq_pkg::entry_t ent;
    int               pos;
    int               n;
    if (mode == dalq_pkg::MODE_ADD) begin
      adds_seen++;
      sum = {1'b0, now_ticks} + {17'd0, dly};
      dl  = sum[32] ? '1 : sum[31:0];
      if (dl <= now_ticks) begin
        queue_result(id, dly, 1'b0, 1'b1);
        immediate_cnt++;
      end else if (pending_alarms.size() >= dalq_pkg::QUEUE_DEPTH) begin
        queue_result(id, dly, 1'b1, 1'b1);
        rejects_cnt++;
      end else begin
        pos = 0;
        while (pos < pending_alarms.size() && pending_alarms[pos].deadline < dl) pos++;
        ent.deadline = dl;
        ent.tag      = id;
        ent.delay    = dly;
        pending_alarms.insert(pos, ent);
      end
    end else begin
      ticks_seen++;
      if (now_ticks != '1) now_ticks++;
      n = 0;
      while (n < pending_alarms.size() && n < dalq_pkg::MAX_RESULTS &&
             pending_alarms[n].deadline <= now_ticks) n++;
      for (int k = 0; k < n; k++) begin
        queue_result(pending_alarms[k].tag, pending_alarms[k].delay, 1'b0, k == n - 1);
      end
      repeat (n) void'(pending_alarms.pop_front());
      expired_cnt += n;
      if (n > biggest_burst) biggest_burst = n;
    end
  endfunction

  task automatic push_cmd(input logic mode, input logic [15:0] dly, input logic [15:0] id);
    alarm_cmd_t cmd;
    cmd.mode   = mode;
    cmd.delay  = dly;
    cmd.tag    = id;
    cmd.drain  = drain_next;
    drain_next = 1'b0;
    alarm_cmd_q.push_back(cmd);
  endtask

  task automatic push_tick();
    push_cmd(dalq_pkg::MODE_TICK, 16'($urandom), 16'($urandom));
  endtask

  // Input side: one transfer per item, a random gap before each item outside calm phases.
  always @(negedge clk) begin : drive_cmds
    logic       vld_nxt;
    alarm_cmd_t cmd;
    vld_nxt = in_tvalid;
    if (!rst_n) begin
      vld_nxt = 1'b0;
    end else begin
      if (in_fire) begin
        vld_nxt  = 1'b0;
        send_gap = calm ? 0 : $urandom_range(0, 15);
      end
      if (!vld_nxt) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (alarm_cmd_q.size() > 0 &&
                     (!alarm_cmd_q[0].drain ||
                      (due_results_q.size() == 0 && settle_cnt == 0))) begin
          cmd = alarm_cmd_q.pop_front();
          if (cmd.drain) drain_pauses++;
          vld_nxt  = 1'b1;
          in_tdata <= {cmd.tag, cmd.delay};
          in_tuser <= cmd.mode;
        end
      end
    end
    in_tvalid <= vld_nxt;
  end

  // Result side: random stalls after each transfer and now and then while idle, outside calm phases.
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_fire) begin
        ready_stall = calm ? 0 : $urandom_range(0, 15);
      end else if (!out_tvalid && ready_stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
        ready_stall = $urandom_range(1, 15);
      end
      if (ready_stall > 0) begin
        ready_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    dalq_pkg::result_t got;
    dalq_pkg::result_t want;
    in_fire  <= in_tvalid && in_tready;
    out_fire <= out_tvalid && out_tready;
    if (due_results_q.size() != 0 || in_tvalid) begin
      settle_cnt <= SETTLE_CYCLES;
    end else if (settle_cnt > 0) begin
      settle_cnt <= settle_cnt - 1;
    end
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_alarm(in_tuser, in_tdata[15:0], in_tdata[31:16]);
      end
      if (out_tvalid && out_tready) begin
        got.tag      = out_tdata[15:0];
        got.delay    = out_tdata[31:16];
        got.rejected = out_tuser;
        got.last     = out_tlast;
        if (due_results_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("ERROR: unexpected result tag=%h delay=%h rejected=%b last=%b",
                     got.tag, got.delay, got.rejected, got.last);
          end
        end else begin
          want = due_results_q.pop_front();
          if (got.tag !== want.tag || got.delay !== want.delay ||
              got.rejected !== want.rejected || got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("ERROR: result mismatch at cycle %0d", cycle_cnt);
              $display("  expected tag=%h delay=%h rejected=%b last=%b",
                       want.tag, want.delay, want.rejected, want.last);
              $display("  actual   tag=%h delay=%h rejected=%b last=%b",
                       got.tag, got.delay, got.rejected, got.last);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int next_drain_at;
    int kind;
    int cnt;
    int dly;

    // Immediate expiry, then two alarms sharing a deadline.
    push_cmd(dalq_pkg::MODE_ADD, 16'h0000, 16'hFFFF);
    push_cmd(dalq_pkg::MODE_ADD, 16'h0001, 16'h1234);
    push_cmd(dalq_pkg::MODE_ADD, 16'h0001, 16'hEDCB);
    push_tick();
    // Fill the table, overflow it, then expire the whole table in one tick.
    for (int i = 0; i < dalq_pkg::QUEUE_DEPTH; i++) begin
      push_cmd(dalq_pkg::MODE_ADD, 16'd3, 16'($urandom));
    end
    push_cmd(dalq_pkg::MODE_ADD, 16'd7, 16'h5A5A);
    push_cmd(dalq_pkg::MODE_ADD, 16'd0, 16'hA5A5);
    push_tick();
    push_tick();
    push_tick();

    drain_next    = 1'b1;
    next_drain_at = alarm_cmd_q.size() + 130;
    while (alarm_cmd_q.size() < 395) begin
      if (alarm_cmd_q.size() >= next_drain_at) begin
        drain_next    = 1'b1;
        next_drain_at += 130;
      end
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        cnt = $urandom_range(1, 6);
        repeat (cnt) begin
          dly = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
          push_cmd(dalq_pkg::MODE_ADD, 16'(dly), 16'($urandom));
        end
        cnt = $urandom_range(1, 8);
        repeat (cnt) push_tick();
      end else if (kind == 6) begin
        cnt = $urandom_range(14, 18);
        repeat (cnt) begin
          push_cmd(dalq_pkg::MODE_ADD, 16'($urandom_range(2, 20)), 16'($urandom));
        end
        cnt = $urandom_range(5, 22);
        repeat (cnt) push_tick();
      end else if (kind == 7) begin
        cnt = $urandom_range(1, 6);
        repeat (cnt) begin
          push_cmd($urandom_range(0, 1) ? dalq_pkg::MODE_TICK : dalq_pkg::MODE_ADD,
                   16'($urandom_range(0, 40)), 16'($urandom));
        end
      end else if (kind == 8) begin
        dly = $urandom_range(1, 6);
        cnt = $urandom_range(2, 5);
        repeat (cnt) push_cmd(dalq_pkg::MODE_ADD, 16'(dly), 16'($urandom));
        repeat (dly) push_tick();
      end else begin
        cnt = $urandom_range(1, 3);
        repeat (cnt) begin
          push_cmd(dalq_pkg::MODE_ADD, 16'($urandom_range(16, 300)), 16'($urandom));
        end
        cnt = $urandom_range(1, 4);
        repeat (cnt) push_tick();
      end
    end
    push_cmd(dalq_pkg::MODE_ADD, 16'hFFFF, 16'h0000);
    push_cmd(dalq_pkg::MODE_ADD, 16'($urandom), 16'($urandom));
    push_cmd(dalq_pkg::MODE_ADD, 16'($urandom), 16'($urandom));
    push_tick();
    push_tick();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (alarm_cmd_q.size() != 0 || in_tvalid) @(posedge clk);
    while (due_results_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Run: %0d adds, %0d ticks, %0d pauses until the queue drained, %0d cycles.",
             adds_seen, ticks_seen, drain_pauses, cycle_cnt);
    $display("Results: %0d expired (up to %0d per tick), %0d at once, %0d refused.",
             expired_cnt, biggest_burst, immediate_cnt, rejects_cnt);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
